>>> rtl/ascm_pkg.sv
// Shared constants and types for the allocator size-class mapper.
package ascm_pkg;

   localparam int PAGE_SHIFT_DEFAULT = 13;
   localparam int SIZE_WIDTH_DEFAULT = 23;

   localparam int MAX_OBJECT_BYTES = 262144;
   localparam int REM_WIDTH        = 19;
   localparam int QUO_WIDTH        = 9;
   localparam int ROUNDED_WIDTH    = 23;
   localparam int ROUNDED_MAX      = (1 << ROUNDED_WIDTH) - 1;
   localparam int INDEX_WIDTH      = 8;
   localparam int BATCH_WIDTH      = 10;
   localparam int PAGES_WIDTH      = 11;
   localparam int PAGES_MAX        = (1 << PAGES_WIDTH) - 1;

   localparam int BAND1_LIMIT = 128;
   localparam int BAND2_LIMIT = 1024;
   localparam int BAND3_LIMIT = 8 * 1024;
   localparam int BAND4_LIMIT = 64 * 1024;

   localparam int BAND1_SHIFT = 3;
   localparam int BAND2_SHIFT = 4;
   localparam int BAND3_SHIFT = 7;
   localparam int BAND4_SHIFT = 10;
   localparam int BAND5_SHIFT = 13;

   localparam int BAND1_CLASSES = 16;
   localparam int BAND2_CLASSES = 56;
   localparam int BAND3_CLASSES = 56;
   localparam int BAND4_CLASSES = 56;

   localparam int BAND2_OFFSET = BAND1_CLASSES;
   localparam int BAND3_OFFSET = BAND2_OFFSET + BAND2_CLASSES;
   localparam int BAND4_OFFSET = BAND3_OFFSET + BAND3_CLASSES;
   localparam int BAND5_OFFSET = BAND4_OFFSET + BAND4_CLASSES;

   localparam int BATCH_MIN = 2;
   localparam int BATCH_MAX = 512;

   typedef struct packed {
      logic [ROUNDED_WIDTH-1:0] rounded_bytes;
      logic [INDEX_WIDTH-1:0]   class_index;
      logic                     out_of_range;
   } ascm_side_type;

endpackage

>>> rtl/ascm_front.sv
// Front stage: band decode, rounded size and size-class index.
module ascm_front #(
   parameter int SIZE_WIDTH      = ascm_pkg::SIZE_WIDTH_DEFAULT,
   parameter int PAGE_SHIFT_BITS = ascm_pkg::PAGE_SHIFT_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_stall,
   input  logic [SIZE_WIDTH-1:0]   in_request_bytes,
   output logic                    out_valid,
   input  logic                    out_stall,
   output logic [SIZE_WIDTH-1:0]   out_req,
   output ascm_pkg::ascm_side_type out_side
);

   localparam int RDW = ascm_pkg::ROUNDED_WIDTH;
   localparam int RW  = ((SIZE_WIDTH > RDW) ? SIZE_WIDTH : RDW) + 1;
   localparam int SW  = ascm_pkg::REM_WIDTH + 1;
   localparam int IW  = ascm_pkg::INDEX_WIDTH;

   function automatic logic [RW-1:0] align_up(input logic [RW-1:0] v, input int shift);
      logic [RW-1:0] mask;
      mask = (RW'(1) << shift) - RW'(1);
      return (v + mask) & ~mask;
   endfunction

   // Granule number within a band, counted from the band's base, plus the band offset.
   function automatic logic [IW-1:0] slot(input logic [SW-1:0] v, input int base,
                                          input int shift, input int offset);
      logic [SW-1:0] t;
      t = ((v - SW'(base) + ((SW'(1) << shift) - SW'(1))) >> shift) - SW'(1) + SW'(offset);
      return t[IW-1:0];
   endfunction

   logic [RW-1:0]           req_wide;
   logic [SW-1:0]           req_small;
   logic                    in_b1, in_b2, in_b3, in_b4, in_b5, is_zero;
   logic [RW-1:0]           rounded_full;
   ascm_pkg::ascm_side_type side_in;
   logic                    valid_ff;
   logic [SIZE_WIDTH-1:0]   req_ff;
   ascm_pkg::ascm_side_type side_ff;

   assign req_wide  = RW'(in_request_bytes);
   assign req_small = req_wide[SW-1:0];
   assign is_zero   = (in_request_bytes == '0);
   assign in_b1     = req_wide <= RW'(ascm_pkg::BAND1_LIMIT);
   assign in_b2     = req_wide <= RW'(ascm_pkg::BAND2_LIMIT);
   assign in_b3     = req_wide <= RW'(ascm_pkg::BAND3_LIMIT);
   assign in_b4     = req_wide <= RW'(ascm_pkg::BAND4_LIMIT);
   assign in_b5     = req_wide <= RW'(ascm_pkg::MAX_OBJECT_BYTES);

   always_comb begin
      if (in_b1) begin
         rounded_full = align_up(req_wide, ascm_pkg::BAND1_SHIFT);
      end else if (in_b2) begin
         rounded_full = align_up(req_wide, ascm_pkg::BAND2_SHIFT);
      end else if (in_b3) begin
         rounded_full = align_up(req_wide, ascm_pkg::BAND3_SHIFT);
      end else if (in_b4) begin
         rounded_full = align_up(req_wide, ascm_pkg::BAND4_SHIFT);
      end else if (in_b5) begin
         rounded_full = align_up(req_wide, ascm_pkg::BAND5_SHIFT);
      end else begin
         rounded_full = align_up(req_wide, PAGE_SHIFT_BITS);
      end
   end

   always_comb begin
      side_in.rounded_bytes = (rounded_full > RW'(ascm_pkg::ROUNDED_MAX)) ?
                              RDW'(ascm_pkg::ROUNDED_MAX) : rounded_full[RDW-1:0];
      side_in.class_index   = '0;
      side_in.out_of_range  = 1'b0;
      if (is_zero || !in_b5) begin
         side_in.out_of_range = 1'b1;
      end else if (in_b1) begin
         side_in.class_index = slot(req_small, 0, ascm_pkg::BAND1_SHIFT, 0);
      end else if (in_b2) begin
         side_in.class_index = slot(req_small, ascm_pkg::BAND1_LIMIT,
                                    ascm_pkg::BAND2_SHIFT, ascm_pkg::BAND2_OFFSET);
      end else if (in_b3) begin
         side_in.class_index = slot(req_small, ascm_pkg::BAND2_LIMIT,
                                    ascm_pkg::BAND3_SHIFT, ascm_pkg::BAND3_OFFSET);
      end else if (in_b4) begin
         side_in.class_index = slot(req_small, ascm_pkg::BAND3_LIMIT,
                                    ascm_pkg::BAND4_SHIFT, ascm_pkg::BAND4_OFFSET);
      end else begin
         side_in.class_index = slot(req_small, ascm_pkg::BAND4_LIMIT,
                                    ascm_pkg::BAND5_SHIFT, ascm_pkg::BAND5_OFFSET);
      end
   end

   assign in_stall = valid_ff && out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && !in_stall) begin
         req_ff  <= in_request_bytes;
         side_ff <= side_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_req   = req_ff;
   assign out_side  = side_ff;

endmodule

>>> rtl/ascm_div_cell.sv
// One cell of the divider chain: settles one quotient bit of the batch division.
module ascm_div_cell #(
   parameter int SIZE_WIDTH = ascm_pkg::SIZE_WIDTH_DEFAULT,
   parameter int BIT        = 0
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_stall,
   input  logic [SIZE_WIDTH-1:0]            in_req,
   input  logic [ascm_pkg::REM_WIDTH-1:0]   in_rem,
   input  logic [ascm_pkg::QUO_WIDTH-1:0]   in_quo,
   input  ascm_pkg::ascm_side_type          in_side,
   output logic                             out_valid,
   input  logic                             out_stall,
   output logic [SIZE_WIDTH-1:0]            out_req,
   output logic [ascm_pkg::REM_WIDTH-1:0]   out_rem,
   output logic [ascm_pkg::QUO_WIDTH-1:0]   out_quo,
   output ascm_pkg::ascm_side_type          out_side
);

   localparam int QW = ascm_pkg::QUO_WIDTH;
   localparam int MW = ascm_pkg::REM_WIDTH;
   localparam int DW = SIZE_WIDTH + QW;

   logic [DW-1:0]           divisor;
   logic [DW-1:0]           rem_wide;
   logic                    fits;
   logic [MW-1:0]           rem_in;
   logic [QW-1:0]           quo_in;
   logic                    valid_ff;
   logic [SIZE_WIDTH-1:0]   req_ff;
   logic [MW-1:0]           rem_ff;
   logic [QW-1:0]           quo_ff;
   ascm_pkg::ascm_side_type side_ff;

   // Restoring step: subtract the divisor aligned to this cell's bit when it fits.
   assign divisor  = DW'(in_req) << BIT;
   assign rem_wide = DW'(in_rem);
   assign fits     = rem_wide >= divisor;
   assign rem_in   = fits ? MW'(rem_wide - divisor) : in_rem;
   assign quo_in   = fits ? (in_quo | (QW'(1) << BIT)) : in_quo;

   assign in_stall = valid_ff && out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && !in_stall) begin
         req_ff  <= in_req;
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_req   = req_ff;
   assign out_rem   = rem_ff;
   assign out_quo   = quo_ff;
   assign out_side  = side_ff;

endmodule

>>> rtl/ascm_tail.sv
// Tail stage: batch clamp, page count and the result register.
module ascm_tail #(
   parameter int SIZE_WIDTH      = ascm_pkg::SIZE_WIDTH_DEFAULT,
   parameter int PAGE_SHIFT_BITS = ascm_pkg::PAGE_SHIFT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_stall,
   input  logic [SIZE_WIDTH-1:0]               in_req,
   input  logic [ascm_pkg::QUO_WIDTH-1:0]      in_quo,
   input  ascm_pkg::ascm_side_type             in_side,
   output logic                                out_valid,
   input  logic                                out_stall,
   output logic [ascm_pkg::ROUNDED_WIDTH-1:0]  out_rounded_bytes,
   output logic [ascm_pkg::INDEX_WIDTH-1:0]    out_class_index,
   output logic                                out_out_of_range,
   output logic [ascm_pkg::BATCH_WIDTH-1:0]    out_batch_count,
   output logic [ascm_pkg::PAGES_WIDTH-1:0]    out_page_count
);

   localparam int BW = ascm_pkg::BATCH_WIDTH;
   localparam int PW = ascm_pkg::PAGES_WIDTH;
   localparam int XW = SIZE_WIDTH + BW;
   localparam int HALF_LIMIT = ascm_pkg::MAX_OBJECT_BYTES / ascm_pkg::BATCH_MIN;

   logic [BW-1:0]           batch_in;
   logic [XW-1:0]           product;
   logic [XW-1:0]           pages_full;
   logic [PW-1:0]           pages_in;
   logic                    valid_ff;
   ascm_pkg::ascm_side_type side_ff;
   logic [BW-1:0]           batch_ff;
   logic [PW-1:0]           pages_ff;

   // The divider chain is exact only between the two clamp points.
   always_comb begin
      if (XW'(in_req) <= XW'(ascm_pkg::BATCH_MAX)) begin
         batch_in = BW'(ascm_pkg::BATCH_MAX);
      end else if (XW'(in_req) > XW'(HALF_LIMIT)) begin
         batch_in = BW'(ascm_pkg::BATCH_MIN);
      end else begin
         batch_in = BW'(in_quo);
      end
   end

   assign product    = XW'(batch_in) * XW'(in_req);
   assign pages_full = product >> PAGE_SHIFT_BITS;

   always_comb begin
      if (pages_full == '0) begin
         pages_in = PW'(1);
      end else if (pages_full > XW'(ascm_pkg::PAGES_MAX)) begin
         pages_in = PW'(ascm_pkg::PAGES_MAX);
      end else begin
         pages_in = pages_full[PW-1:0];
      end
   end

   assign in_stall = valid_ff && out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && !in_stall) begin
         side_ff  <= in_side;
         batch_ff <= batch_in;
         pages_ff <= pages_in;
      end
   end

   assign out_valid         = valid_ff;
   assign out_rounded_bytes = side_ff.rounded_bytes;
   assign out_class_index   = side_ff.class_index;
   assign out_out_of_range  = side_ff.out_of_range;
   assign out_batch_count   = batch_ff;
   assign out_page_count    = pages_ff;

endmodule

>>> rtl/allocator_size_class_mapper_core.sv
// Top level of the allocator size-class mapper: front stage, divider cell chain, tail stage.
//
// The mapper takes one request size per beat and returns one result beat carrying the
// rounded size, the size-class index, an out-of-range flag, the batch count and the
// page count. It accepts a new request every clock cycle unless a stall on the result
// side has filled every stage. It is built from one front stage that decodes the band,
// rounds the size and numbers the class, a chain of nine divider cells that each
// settle one bit of the batch quotient, and a tail stage that clamps the batch,
// multiplies it by the request and registers the result. Every stage holds its own
// beat, so stalls on the result side back up one stage at a time and the chain keeps
// taking requests while it still has empty stages. Requests above the largest small
// object, and a zero request, raise out_of_range with class index zero; the batch
// and page counts are always computed from the raw request size.
module allocator_size_class_mapper_core #(
   parameter int SIZE_WIDTH      = ascm_pkg::SIZE_WIDTH_DEFAULT,
   parameter int PAGE_SHIFT_BITS = ascm_pkg::PAGE_SHIFT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [SIZE_WIDTH-1:0]               req_request_bytes,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ascm_pkg::ROUNDED_WIDTH-1:0]  rsp_rounded_bytes,
   output logic [ascm_pkg::INDEX_WIDTH-1:0]    rsp_class_index,
   output logic                                rsp_out_of_range,
   output logic [ascm_pkg::BATCH_WIDTH-1:0]    rsp_batch_count,
   output logic [ascm_pkg::PAGES_WIDTH-1:0]    rsp_page_count
);

   localparam int NC = ascm_pkg::QUO_WIDTH;
   localparam int MW = ascm_pkg::REM_WIDTH;

   // Link k runs from stage k into stage k + 1; link 0 leaves the front stage.
   logic [NC:0]             chain_valid;
   logic [NC:0]             chain_stall;
   logic [SIZE_WIDTH-1:0]   chain_req  [NC+1];
   logic [MW-1:0]           chain_rem  [NC+1];
   logic [NC-1:0]           chain_quo  [NC+1];
   ascm_pkg::ascm_side_type chain_side [NC+1];

   ascm_front #(
      .SIZE_WIDTH      (SIZE_WIDTH),
      .PAGE_SHIFT_BITS (PAGE_SHIFT_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (req_valid),
      .in_stall         (req_stall),
      .in_request_bytes (req_request_bytes),
      .out_valid        (chain_valid[0]),
      .out_stall        (chain_stall[0]),
      .out_req          (chain_req[0]),
      .out_side         (chain_side[0])
   );

   // The division always starts from the largest object size with an empty quotient.
   assign chain_rem[0] = MW'(ascm_pkg::MAX_OBJECT_BYTES);
   assign chain_quo[0] = '0;

   for (genvar k = 0; k < NC; k++) begin : g_cell
      ascm_div_cell #(
         .SIZE_WIDTH (SIZE_WIDTH),
         .BIT        (NC - 1 - k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[k]),
         .in_stall  (chain_stall[k]),
         .in_req    (chain_req[k]),
         .in_rem    (chain_rem[k]),
         .in_quo    (chain_quo[k]),
         .in_side   (chain_side[k]),
         .out_valid (chain_valid[k+1]),
         .out_stall (chain_stall[k+1]),
         .out_req   (chain_req[k+1]),
         .out_rem   (chain_rem[k+1]),
         .out_quo   (chain_quo[k+1]),
         .out_side  (chain_side[k+1])
      );
   end

   // The final remainder is not needed past the last cell.
   ascm_tail #(
      .SIZE_WIDTH      (SIZE_WIDTH),
      .PAGE_SHIFT_BITS (PAGE_SHIFT_BITS)
   ) u_tail (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (chain_valid[NC]),
      .in_stall          (chain_stall[NC]),
      .in_req            (chain_req[NC]),
      .in_quo            (chain_quo[NC]),
      .in_side           (chain_side[NC]),
      .out_valid         (rsp_valid),
      .out_stall         (rsp_stall),
      .out_rounded_bytes (rsp_rounded_bytes),
      .out_class_index   (rsp_class_index),
      .out_out_of_range  (rsp_out_of_range),
      .out_batch_count   (rsp_batch_count),
      .out_page_count    (rsp_page_count)
   );

`ifndef SYNTHESIS
   // An out-of-range beat never carries a class number.
   a_oor_index : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_range) |-> (rsp_class_index == '0))
      else $error("out-of-range result with nonzero class index");

   // The batch clamp keeps the count between its two limits.
   a_batch_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_batch_count >= ascm_pkg::BATCH_WIDTH'(ascm_pkg::BATCH_MIN)) &&
                     (rsp_batch_count <= ascm_pkg::BATCH_WIDTH'(ascm_pkg::BATCH_MAX))))
      else $error("batch count outside its clamp range");

   // A batch always needs at least one page.
   a_pages_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_page_count != '0))
      else $error("zero page count");

   // An in-range size is rounded to a multiple of the smallest granule.
   a_rounded_aligned : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_out_of_range) |-> (rsp_rounded_bytes[2:0] == 3'b000))
      else $error("in-range rounded size not aligned to the smallest granule");

   // A stalled result holds the last divider cell back, so no beat is lost.
   a_stall_chain : assert property (@(posedge clock) disable iff (reset)
      (chain_valid[NC] && rsp_valid && rsp_stall) |-> chain_stall[NC])
      else $error("last cell not stalled behind a stalled result");
`endif

endmodule

>>> tb/sv/allocator_size_class_mapper_core_tb.sv
// Self-checking testbench for the allocator size-class mapper core.
//
// Every request beat that the core accepts is run through a predictor written in this
// file, and the predicted answer is queued. A checker process compares each result beat,
// field by field, against the oldest queued answer. Both sides of the core idle at
// random: the sender waits a drawn number of cycles before each request, and the
// result side raises rsp_stall for a drawn number of cycles before each result.
// The stimulus covers the band edges and the special cases first, then long random
// parts, mostly biased toward each band and its boundaries, and a back-to-back run.
module allocator_size_class_mapper_core_tb;

   localparam int SIZE_W    = ascm_pkg::SIZE_WIDTH_DEFAULT;
   localparam int PAGE_BITS = ascm_pkg::PAGE_SHIFT_DEFAULT;

   // The core's pipeline is QUO_WIDTH + 2 stages deep, so this many quiet cycles at the
   // end leave ample room for any stray result beat to show up.
   localparam int TAIL_CYCLES = 3 * (ascm_pkg::QUO_WIDTH + 2);

   // One full answer, with the request kept alongside for readable error lines.
   typedef struct packed {
      logic [SIZE_W-1:0]                  request;
      logic [ascm_pkg::ROUNDED_WIDTH-1:0] rounded_bytes;
      logic [ascm_pkg::INDEX_WIDTH-1:0]   class_index;
      logic                               out_of_range;
      logic [ascm_pkg::BATCH_WIDTH-1:0]   batch_count;
      logic [ascm_pkg::PAGES_WIDTH-1:0]   page_count;
   } size_answer_type;

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               req_valid;
   logic                               req_stall;
   logic [SIZE_W-1:0]                  req_request_bytes;
   logic                               rsp_valid;
   logic                               rsp_stall;
   logic [ascm_pkg::ROUNDED_WIDTH-1:0] rsp_rounded_bytes;
   logic [ascm_pkg::INDEX_WIDTH-1:0]   rsp_class_index;
   logic                               rsp_out_of_range;
   logic [ascm_pkg::BATCH_WIDTH-1:0]   rsp_batch_count;
   logic [ascm_pkg::PAGES_WIDTH-1:0]   rsp_page_count;

   size_answer_type pending_answers[$];
   int              mismatch_count = 0;

   // When set, both sides run without any idle cycles.
   bit              no_idle = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   allocator_size_class_mapper_core #(
      .SIZE_WIDTH      (SIZE_W),
      .PAGE_SHIFT_BITS (PAGE_BITS)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_request_bytes (req_request_bytes),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_rounded_bytes (rsp_rounded_bytes),
      .rsp_class_index   (rsp_class_index),
      .rsp_out_of_range  (rsp_out_of_range),
      .rsp_batch_count   (rsp_batch_count),
      .rsp_page_count    (rsp_page_count)
   );

   // ---------------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------------

   // Rounds a size up to a multiple of 2^shift.
   function automatic longint unsigned round_to_granule(input longint unsigned bytes,
                                                        input int shift);
      return ((bytes + (64'd1 << shift) - 64'd1) >> shift) << shift;
   endfunction

   // Number of 2^shift granules needed to cover a nonzero size, less one; this is the
   // class slot inside a band.
   function automatic longint unsigned slot_of(input longint unsigned bytes,
                                               input int shift);
      return ((bytes + (64'd1 << shift) - 64'd1) >> shift) - 64'd1;
   endfunction

   function automatic size_answer_type map_request(input logic [SIZE_W-1:0] size);
      size_answer_type   answer;
      longint unsigned   bytes;
      longint unsigned   rounded;
      longint unsigned   slot;
      longint unsigned   batch;
      longint unsigned   pages;
      logic              too_big;
      bytes   = 64'(size);
      slot    = 0;
      too_big = 1'b0;

      // Each band has its own granule; sizes past the largest small object go to pages.
      if (bytes <= ascm_pkg::BAND1_LIMIT)
         rounded = round_to_granule(bytes, ascm_pkg::BAND1_SHIFT);
      else if (bytes <= ascm_pkg::BAND2_LIMIT)
         rounded = round_to_granule(bytes, ascm_pkg::BAND2_SHIFT);
      else if (bytes <= ascm_pkg::BAND3_LIMIT)
         rounded = round_to_granule(bytes, ascm_pkg::BAND3_SHIFT);
      else if (bytes <= ascm_pkg::BAND4_LIMIT)
         rounded = round_to_granule(bytes, ascm_pkg::BAND4_SHIFT);
      else if (bytes <= ascm_pkg::MAX_OBJECT_BYTES)
         rounded = round_to_granule(bytes, ascm_pkg::BAND5_SHIFT);
      else
         rounded = round_to_granule(bytes, PAGE_BITS);
      if (rounded > ascm_pkg::ROUNDED_MAX)
         rounded = ascm_pkg::ROUNDED_MAX;

      // A zero request and an oversized one both flag out of range with class zero.
      if (bytes == 0)
         too_big = 1'b1;
      else if (bytes <= ascm_pkg::BAND1_LIMIT)
         slot = slot_of(bytes, ascm_pkg::BAND1_SHIFT);
      else if (bytes <= ascm_pkg::BAND2_LIMIT)
         slot = slot_of(bytes - ascm_pkg::BAND1_LIMIT, ascm_pkg::BAND2_SHIFT)
                + ascm_pkg::BAND2_OFFSET;
      else if (bytes <= ascm_pkg::BAND3_LIMIT)
         slot = slot_of(bytes - ascm_pkg::BAND2_LIMIT, ascm_pkg::BAND3_SHIFT)
                + ascm_pkg::BAND3_OFFSET;
      else if (bytes <= ascm_pkg::BAND4_LIMIT)
         slot = slot_of(bytes - ascm_pkg::BAND3_LIMIT, ascm_pkg::BAND4_SHIFT)
                + ascm_pkg::BAND4_OFFSET;
      else if (bytes <= ascm_pkg::MAX_OBJECT_BYTES)
         slot = slot_of(bytes - ascm_pkg::BAND4_LIMIT, ascm_pkg::BAND5_SHIFT)
                + ascm_pkg::BAND5_OFFSET;
      else
         too_big = 1'b1;

      // The batch uses the raw size; a zero size behaves like an endless quotient.
      if (bytes == 0) begin
         batch = ascm_pkg::BATCH_MAX;
      end else begin
         batch = ascm_pkg::MAX_OBJECT_BYTES / bytes;
         if (batch < ascm_pkg::BATCH_MIN)
            batch = ascm_pkg::BATCH_MIN;
         else if (batch > ascm_pkg::BATCH_MAX)
            batch = ascm_pkg::BATCH_MAX;
      end

      pages = (batch * bytes) >> PAGE_BITS;
      if (pages == 0)
         pages = 1;
      if (pages > ascm_pkg::PAGES_MAX)
         pages = ascm_pkg::PAGES_MAX;

      answer.request       = size;
      answer.rounded_bytes = rounded[ascm_pkg::ROUNDED_WIDTH-1:0];
      answer.class_index   = slot[ascm_pkg::INDEX_WIDTH-1:0];
      answer.out_of_range  = too_big;
      answer.batch_count   = batch[ascm_pkg::BATCH_WIDTH-1:0];
      answer.page_count    = pages[ascm_pkg::PAGES_WIDTH-1:0];
      return answer;
   endfunction

   // ---------------------------------------------------------------------------------
   // Driving, idling and checking
   // ---------------------------------------------------------------------------------

   function automatic int idle_draw();
      if (no_idle)
         return 0;
      return int'($urandom_range(0, 19));
   endfunction

   task automatic report_mismatch(input string message);
      $display("ERROR at %0t: %s", $time, message);
      mismatch_count++;
   endtask

   // Sends one request beat. The idle gap comes first, with valid low; valid then stays
   // high, and the payload stays put, until the core takes the beat. When the next call
   // draws no gap, valid simply remains high across the two beats.
   task automatic send_request(input logic [SIZE_W-1:0] size);
      int gap;
      gap = idle_draw();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid         <= 1'b1;
      req_request_bytes <= size;
      do
         @(posedge clock);
      while (req_stall);
      pending_answers.push_back(map_request(size));
   endtask

   task automatic release_request_channel();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_for_all_answers();
      while (pending_answers.size() != 0)
         @(posedge clock);
   endtask

   // The result side draws a hold-off before each result beat, then waits for the beat.
   initial begin
      int hold;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         hold = idle_draw();
         if (hold > 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (hold - 1) @(negedge clock);
            @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do
            @(posedge clock);
         while (!(rsp_valid && !rsp_stall));
      end
   end

   // Every result beat is checked against the oldest predicted answer.
   always @(posedge clock) begin
      size_answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            report_mismatch("result beat with no request outstanding");
         end else begin
            want = pending_answers.pop_front();
            if (rsp_rounded_bytes !== want.rounded_bytes)
               report_mismatch($sformatf("request %0d: rounded_bytes is %0d, expected %0d",
                                         want.request, rsp_rounded_bytes,
                                         want.rounded_bytes));
            if (rsp_class_index !== want.class_index)
               report_mismatch($sformatf("request %0d: class_index is %0d, expected %0d",
                                         want.request, rsp_class_index,
                                         want.class_index));
            if (rsp_out_of_range !== want.out_of_range)
               report_mismatch($sformatf("request %0d: out_of_range is %0d, expected %0d",
                                         want.request, rsp_out_of_range,
                                         want.out_of_range));
            if (rsp_batch_count !== want.batch_count)
               report_mismatch($sformatf("request %0d: batch_count is %0d, expected %0d",
                                         want.request, rsp_batch_count,
                                         want.batch_count));
            if (rsp_page_count !== want.page_count)
               report_mismatch($sformatf("request %0d: page_count is %0d, expected %0d",
                                         want.request, rsp_page_count,
                                         want.page_count));
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------

   // Draws a size from one band at a time, from the oversized range, near one of the
   // interesting boundaries, or from the whole field so that every bit is exercised.
   function automatic logic [SIZE_W-1:0] pick_request();
      int unsigned edge_list[8];
      int unsigned pick;
      edge_list = '{ascm_pkg::BAND1_LIMIT, ascm_pkg::BAND2_LIMIT, ascm_pkg::BAND3_LIMIT,
                    ascm_pkg::BAND4_LIMIT, ascm_pkg::MAX_OBJECT_BYTES, ascm_pkg::BATCH_MAX,
                    ascm_pkg::MAX_OBJECT_BYTES / 2,
                    ascm_pkg::ROUNDED_MAX - (1 << PAGE_BITS) + 1};
      case ($urandom_range(0, 7))
         0: return SIZE_W'($urandom_range(1, ascm_pkg::BAND1_LIMIT));
         1: return SIZE_W'($urandom_range(ascm_pkg::BAND1_LIMIT + 1, ascm_pkg::BAND2_LIMIT));
         2: return SIZE_W'($urandom_range(ascm_pkg::BAND2_LIMIT + 1, ascm_pkg::BAND3_LIMIT));
         3: return SIZE_W'($urandom_range(ascm_pkg::BAND3_LIMIT + 1, ascm_pkg::BAND4_LIMIT));
         4: return SIZE_W'($urandom_range(ascm_pkg::BAND4_LIMIT + 1,
                                          ascm_pkg::MAX_OBJECT_BYTES));
         5: return SIZE_W'($urandom_range(ascm_pkg::MAX_OBJECT_BYTES + 1, 4194304));
         6: begin
            pick = edge_list[3'($urandom_range(0, 7))];
            return SIZE_W'(pick + $urandom_range(0, 16) - 8);
         end
         default: return SIZE_W'($urandom);
      endcase
   endfunction

   // Band edges, the clamp points of the batch count, and the special cases: zero,
   // oversized requests and a page rounding that overflows the rounded-size field.
   task automatic test_directed_edges();
      int unsigned sizes[$];
      sizes = '{0, 1, 7, 8, 9, 128, 129, 1024, 1025, 8192, 8193, 65536, 65537,
                262143, 262144, 262145, 511, 512, 513, 131072, 131073, 4194304,
                ascm_pkg::ROUNDED_MAX - (1 << PAGE_BITS) + 1, ascm_pkg::ROUNDED_MAX};
      foreach (sizes[i])
         send_request(SIZE_W'(sizes[i]));
   endtask

   task automatic test_random_bands(input int count);
      repeat (count)
         send_request(pick_request());
   endtask

   // Lets the pipeline run empty once in the middle of the run.
   task automatic test_drain_pause();
      release_request_channel();
      wait_for_all_answers();
      test_random_bands(50);
   endtask

   // Back-to-back beats on both sides, so that the pipeline runs full.
   task automatic test_back_to_back(input int count);
      no_idle = 1'b1;
      test_random_bands(count);
      no_idle = 1'b0;
   endtask

   task automatic test_full_field(input int count);
      repeat (count)
         send_request(SIZE_W'($urandom));
   endtask

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_request_bytes = '0;
      rsp_stall         = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_edges();
      test_random_bands(500);
      test_drain_pause();
      test_back_to_back(250);
      test_full_field(150);
      test_random_bands(150);

      release_request_channel();
      wait_for_all_answers();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Ends the run with an error if it has not finished in time, with a wide margin.
   initial begin
      #4000000;
      $display("ERROR: run did not finish in time, %0d answers outstanding",
               pending_answers.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> sim.f
rtl/ascm_pkg.sv
rtl/ascm_front.sv
rtl/ascm_div_cell.sv
rtl/ascm_tail.sv
rtl/allocator_size_class_mapper_core.sv
tb/sv/allocator_size_class_mapper_core_tb.sv
